// ===== hw/rtl/glmd_pkg.sv =====
// glmd_pkg: shared types, constants and grid helper functions of the grid luma motion detector
// depends on nothing; used by the interfaces, the divider and the top level
package glmd_pkg;

    localparam int GRID_WIDTH    = 8;
    localparam int GRID_HEIGHT   = 8;
    localparam int MAX_FRAME_DIM = 4095;
    localparam int CELL_TOTAL    = GRID_WIDTH * GRID_HEIGHT;

    localparam int DIM_W  = 12;
    localparam int PIX_W  = 8;
    localparam int THR_W  = 8;
    localparam int CHG_W  = 7;
    localparam int Q_W    = 8;
    localparam int CNT_W  = 2 * DIM_W;
    localparam int SUM_W  = CNT_W + Q_W;
    localparam int GX_W   = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int GY_W   = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CELL_W = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd240;
    localparam logic [THR_W-1:0] RST_THRESHOLD    = 8'd20;
    localparam logic [CHG_W-1:0] RST_MIN_CHANGED  = 7'd8;

    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_MIN_CHANGED  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_PIX,
        S_LOAD,
        S_START,
        S_WAIT,
        S_CELL,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) r = DIM_W'(1);
        if (32'(d) > MAX_FRAME_DIM) r = DIM_W'(MAX_FRAME_DIM);
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [2*PIX_W+1:0] s;
        s = (2*PIX_W+2)'(LUMA_R * r) + (2*PIX_W+2)'(LUMA_G * g)
          + (2*PIX_W+2)'(LUMA_B * b);
        return s[2*PIX_W-1:PIX_W];
    endfunction

    // column boundary floor(i*w/GRID_WIDTH)
    function automatic logic [DIM_W-1:0] col_edge(input logic [GX_W:0] i,
                                                  input logic [DIM_W-1:0] d);
        logic [GX_W+DIM_W:0] p;
        p = (GX_W+DIM_W+1)'(i) * (GX_W+DIM_W+1)'(d);
        return DIM_W'(p / GRID_WIDTH);
    endfunction

    function automatic logic [DIM_W-1:0] row_edge(input logic [GY_W:0] i,
                                                  input logic [DIM_W-1:0] d);
        logic [GY_W+DIM_W:0] p;
        p = (GY_W+DIM_W+1)'(i) * (GY_W+DIM_W+1)'(d);
        return DIM_W'(p / GRID_HEIGHT);
    endfunction

    // largest grid column whose left boundary is at or before pos
    function automatic logic [GX_W-1:0] grid_col(input logic [DIM_W-1:0] pos,
                                                 input logic [DIM_W-1:0] d);
        logic [GX_W-1:0] g;
        g = '0;
        for (int k = 1; k < GRID_WIDTH; k++) begin
            if (col_edge((GX_W+1)'(k), d) <= pos) g = GX_W'(k);
        end
        return g;
    endfunction

    function automatic logic [GY_W-1:0] grid_row(input logic [DIM_W-1:0] pos,
                                                 input logic [DIM_W-1:0] d);
        logic [GY_W-1:0] g;
        g = '0;
        for (int k = 1; k < GRID_HEIGHT; k++) begin
            if (row_edge((GY_W+1)'(k), d) <= pos) g = GY_W'(k);
        end
        return g;
    endfunction

endpackage

// ===== hw/rtl/glmd_if.sv =====
// glmd_if: valid/ready channels of the grid luma motion detector (pixels, results, config)
// depends on glmd_pkg
interface glmd_pix_if;
    import glmd_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    modport source(output valid, op, red, green, blue, input ready);
    modport sink(input valid, op, red, green, blue, output ready);
endinterface

interface glmd_res_if;
    import glmd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CHG_W-1:0] cell_change_cnt;
    logic             ref_ok;
    logic             motion_flag;
    logic             was_reference;
    modport source(output valid, cell_change_cnt, ref_ok, motion_flag,
                   was_reference, input ready);
    modport sink(input valid, cell_change_cnt, ref_ok, motion_flag,
                 was_reference, output ready);
endinterface

interface glmd_cfg_if;
    import glmd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/grid_luma_motion_detector.sv =====
// grid_luma_motion_detector: top level, pixel accumulation, cell settling and result output
// depends on glmd_pkg, glmd_if, glmd_ram and glmd_div
// Pixels are taken one per clock while a grid row is being accumulated. On the pixel that
// closes a grid row the block stops taking pixels and settles the row's cells one by one:
// each cell takes a count multiply, an 8-step iterative divide of the luma sum, then a read
// of the 64-entry reference ram, which is written back on a reference frame. After the last
// pixel of a frame a scan over the grid rows follows, plus a settle of any grid row that
// holds no pixel rows, and then one result per frame goes to the output register, which may
// wait for its transfer while the next frame's pixels are already being taken. No reset pass
// is needed: the reference ram's read data is only used once a reference frame has written
// every entry.
module grid_luma_motion_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glmd_pix_if.sink    i_pix,
    glmd_res_if.source  o_res,
    glmd_cfg_if.sink    i_cfg
);
    import glmd_pkg::*;

    localparam logic [GX_W-1:0] GX_LAST = GX_W'(GRID_WIDTH - 1);
    localparam logic [GY_W-1:0] GY_LAST = GY_W'(GRID_HEIGHT - 1);

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_fw, r_fh;
    logic [THR_W-1:0] r_thr;
    logic [CHG_W-1:0] r_min;
    logic [DIM_W-1:0] r_col, r_row;
    logic             r_op;
    logic             r_ref_valid;
    logic [CHG_W-1:0] r_changed;
    logic [GX_W-1:0]  r_gx;
    logic [GY_W-1:0]  r_gy;
    logic             r_end;
    logic             r_scan;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_sums [GRID_WIDTH];
    logic             r_out_valid;
    logic [CHG_W-1:0] r_out_cc;
    logic             r_out_rr, r_out_md, r_out_wr;

    logic [DIM_W-1:0]  w, h;
    logic              pix_acc;
    logic [GX_W-1:0]   pix_gx;
    logic [GY_W-1:0]   cur_gy, nxt_gy;
    logic              row_done, last_row, need_finish;
    logic [PIX_W-1:0]  luma;
    logic [DIM_W-1:0]  rows_gy, cols_gx;
    logic [CELL_W-1:0] cell_addr;
    logic [Q_W-1:0]    ref_val, quot, diff;
    logic              div_done;
    t_div_req          div_req;
    logic              out_load;
    logic              ram_we;

    assign w = clamp_dim(r_fw);
    assign h = clamp_dim(r_fh);

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= RST_FRAME_WIDTH;
            r_fh  <= RST_FRAME_HEIGHT;
            r_thr <= RST_THRESHOLD;
            r_min <= RST_MIN_CHANGED;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_FRAME_WIDTH:  r_fw  <= i_cfg.data;
                REG_FRAME_HEIGHT: r_fh  <= i_cfg.data;
                REG_THRESHOLD:    r_thr <= i_cfg.data[THR_W-1:0];
                REG_MIN_CHANGED:  r_min <= i_cfg.data[CHG_W-1:0];
                default:          r_fw  <= r_fw;
            endcase
        end
    end

    // pixel side
    assign i_pix.ready = (r_state == S_PIX);
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign pix_gx      = grid_col(r_col, w);
    assign cur_gy      = grid_row(r_row, h);
    assign nxt_gy      = grid_row(r_row + 1'b1, h);
    assign row_done    = ({1'b0, r_col} + 1'b1) >= {1'b0, w};
    assign last_row    = ({1'b0, r_row} + 1'b1) >= {1'b0, h};
    assign need_finish = last_row || (nxt_gy != cur_gy);
    assign luma        = luma_of(i_pix.red, i_pix.green, i_pix.blue);

    // cell geometry of the row being settled
    assign rows_gy = row_edge({1'b0, r_gy} + 1'b1, h) - row_edge({1'b0, r_gy}, h);
    assign cols_gx = col_edge({1'b0, r_gx} + 1'b1, w) - col_edge({1'b0, r_gx}, w);

    assign cell_addr = CELL_W'(int'(r_gy) * GRID_WIDTH + int'(r_gx));
    assign ram_we    = (r_state == S_CELL) && r_op;

    glmd_ram #(.WIDTH(Q_W), .DEPTH(CELL_TOTAL)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cell_addr),
        .i_wdata (quot),
        .i_raddr (cell_addr),
        .o_rdata (ref_val)
    );

    assign div_req.start = (r_state == S_START);
    assign div_req.num   = r_sums[r_gx];
    assign div_req.den   = r_cnt;

    glmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign diff     = (quot >= ref_val) ? (quot - ref_val) : (ref_val - quot);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PIX;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_PIX: begin
                if (pix_acc && row_done && need_finish) n_state = S_LOAD;
            end
            S_LOAD:  n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_done) n_state = S_CELL;
            end
            S_CELL: begin
                if (r_gx != GX_LAST) begin
                    n_state = S_LOAD;
                end else if (r_scan) begin
                    n_state = (r_gy == GY_LAST) ? S_OUT : S_SCAN;
                end else if (r_end) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_SCAN: begin
                // grid rows without pixel rows still settle, as empty cells
                if (rows_gy == '0) begin
                    n_state = S_LOAD;
                end else if (r_gy == GY_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) n_state = S_PIX;
            end
            default: n_state = S_PIX;
        endcase
    end

    // result register: loaded at frame end, cleared by its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_op        <= 1'b0;
            r_ref_valid <= 1'b0;
            r_changed   <= '0;
            r_gx        <= '0;
            r_gy        <= '0;
            r_end       <= 1'b0;
            r_scan      <= 1'b0;
            for (int k = 0; k < GRID_WIDTH; k++) r_sums[k] <= '0;
        end else begin
            case (r_state)
                S_PIX: begin
                    if (pix_acc) begin
                        if (r_col == '0 && r_row == '0) r_op <= i_pix.op;
                        r_sums[pix_gx] <= r_sums[pix_gx] + SUM_W'(luma);
                        if (!row_done) begin
                            r_col <= r_col + 1'b1;
                        end else begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : r_row + 1'b1;
                            if (need_finish) begin
                                r_gy   <= cur_gy;
                                r_gx   <= '0;
                                r_end  <= last_row;
                                r_scan <= 1'b0;
                            end
                        end
                    end
                end
                S_LOAD: r_cnt <= CNT_W'(rows_gy) * CNT_W'(cols_gx);
                S_CELL: begin
                    r_sums[r_gx] <= '0;
                    if (!r_op && r_ref_valid && diff >= r_thr && r_changed != CHG_MAX) begin
                        r_changed <= r_changed + 1'b1;
                    end
                    if (r_gx != GX_LAST) begin
                        r_gx <= r_gx + 1'b1;
                    end else begin
                        r_gx <= '0;
                        if (r_scan) begin
                            if (r_gy != GY_LAST) r_gy <= r_gy + 1'b1;
                        end else if (r_end) begin
                            r_scan <= 1'b1;
                            r_gy   <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (rows_gy != '0 && r_gy != GY_LAST) r_gy <= r_gy + 1'b1;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_op) begin
                            r_out_cc <= '0;
                            r_out_rr <= 1'b1;
                            r_out_md <= 1'b0;
                            r_out_wr <= 1'b1;
                        end else begin
                            r_out_cc <= r_ref_valid ? r_changed : '0;
                            r_out_rr <= r_ref_valid;
                            r_out_md <= !r_ref_valid || (r_changed >= r_min);
                            r_out_wr <= 1'b0;
                        end
                        r_ref_valid <= r_ref_valid | r_op;
                        r_changed   <= '0;
                        r_end       <= 1'b0;
                        r_scan      <= 1'b0;
                        for (int k = 0; k < GRID_WIDTH; k++) r_sums[k] <= '0;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.cell_change_cnt = r_out_cc;
    assign o_res.ref_ok          = r_out_rr;
    assign o_res.motion_flag     = r_out_md;
    assign o_res.was_reference   = r_out_wr;

    // no pixel transfer while a row is being settled
    a_no_pix_in_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PIX) |-> !i_pix.ready)
        else $error("pixel ready outside accumulation");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside wait state");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_changed == '0) && r_out_valid)
        else $error("changed count not cleared after result load");

endmodule

// ===== hw/rtl/glmd_ram.sv =====
// glmd_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module glmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/glmd_div.sv =====
// glmd_div: iterative divider, one quotient bit per cycle, quotient saturated to 8 bits
// depends on glmd_pkg
module glmd_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  glmd_pkg::t_div_req    i_req,
    output logic                  o_done,
    output logic [glmd_pkg::Q_W-1:0] o_quot
);
    import glmd_pkg::*;

    localparam int BIT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [BIT_W-1:0] r_bit;
    logic [SUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    logic [SUM_W-1:0] trial;

    assign trial  = SUM_W'(r_den) << r_bit;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= i_req.num;
                r_den <= i_req.den;
                r_bit <= BIT_W'(Q_W - 1);
                if (i_req.den == '0) begin
                    // empty cell
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if (i_req.num >= {i_req.den, {Q_W{1'b0}}}) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_q    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem        <= r_rem - trial;
                    r_q[r_bit]   <= 1'b1;
                end
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end
endmodule
